>>> hdl/sdt_pkg.sv
// ----------------------------------------------------------------------------
// Switch debounce package
// Shared constants, codes, configuration type and the level decision
// function for the switch debouncer with tolerance.
// ----------------------------------------------------------------------------
`default_nettype none

package sdt_pkg;

    // Depth of the sliding sample window.
    localparam int SAMPLES_DEPTH = 8;
    localparam int ONES_W        = $clog2(SAMPLES_DEPTH + 1);
    localparam logic [7:0] DEPTH_COUNT = 8'(SAMPLES_DEPTH);

    // Configuration port geometry.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_WINDOW_LENGTH = 3'd0;
    localparam logic [2:0] REG_TOLERANCE     = 3'd1;
    localparam logic [2:0] REG_ACTIVE_LEVEL  = 3'd2;
    localparam logic [2:0] REG_IDLE_LEVEL    = 3'd3;
    localparam logic [2:0] REG_WINDOW_MODE   = 3'd4;

    typedef enum logic {
        ACT_SAMPLE  = 1'b0,
        ACT_RESTART = 1'b1
    } action_t;

    typedef enum logic {
        MODE_BLOCK   = 1'b0,
        MODE_SLIDING = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } event_t;

    typedef enum logic [1:0] {
        LVL_LOW       = 2'd0,
        LVL_HIGH      = 2'd1,
        LVL_UNDECIDED = 2'd2
    } level_t;

    typedef struct packed {
        logic [7:0] window_length;
        logic [7:0] tolerance;
        logic       active_level;
        logic       idle_level;
        mode_t      window_mode;
    } cfg_t;

    // Clean low when few ones, clean high when few zeros, else undecided.
    function automatic level_t judge(input logic [7:0] ones,
                                     input logic [7:0] count,
                                     input logic [7:0] tol);
        level_t res;
        res = LVL_UNDECIDED;
        if (ones <= tol) begin
            res = LVL_LOW;
        end else if (({1'b0, ones} + {1'b0, tol}) >= {1'b0, count}) begin
            res = LVL_HIGH;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hdl/switch_debounce_with_tolerance.sv
// ----------------------------------------------------------------------------
// Switch debounce with tolerance
// Debounces one switch pin, one sample per transfer, in block window or
// sliding window mode, and reports press and release events.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload
//   s_*       in         tuser[0] action, tdata[0] pin_level
//   m_*       out        tdata[1:0] event_res, tdata[2] stable_level
//   p*        in/out     APB registers at byte addresses 0, 4, 8, 12, 16
//
// One input transfer is taken every cycle while the output is not stalled;
// an accepted item passes the input register, then the result register,
// before the result transfer can complete.
// The rate is set by the state update between the two registers.
// Reset is synchronous on aresetn and loads the register reset values and
// the idle-high debounce state.
// A stalled output holds the result register and then the input register;
// s_tready falls only when both hold an item.
//
`default_nettype none

module switch_debounce_with_tolerance (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // Input stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [0] pin_level
    input  wire logic [0:0]                  s_tuser,   // [0] action
    // Result stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [7:0]                  m_tdata,   // [1:0] event_res, [2] stable_level
    // Configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sdt_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [sdt_pkg::DATA_W-1:0]  pwdata,
    output logic      [sdt_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    sdt_pkg::cfg_t   cfg;
    sdt_pkg::event_t out_event;
    logic            out_stable;

    // Configuration registers.
    sdt_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Debounce datapath.
    sdt_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_action  (sdt_pkg::action_t'(s_tuser[0])),
        .in_pin     (s_tdata[0]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_event  (out_event),
        .out_stable (out_stable)
    );

    assign m_tdata = {5'd0, out_stable, out_event};

`ifndef SYNTHESIS
    // The input side only stalls while a finished result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a waiting result");

    // A press event leaves the stable level at the press level.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == sdt_pkg::EV_PRESS) |->
            (m_tdata[2] == cfg.active_level))
        else $error("press event with stable level off the press level");

    // A release event leaves the stable level away from the press level.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == sdt_pkg::EV_RELEASE) |->
            (m_tdata[2] != cfg.active_level))
        else $error("release event with stable level at the press level");

    // An event code beyond release never appears.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("invalid event code on result");
`endif

endmodule

`default_nettype wire

>>> hdl/sdt_apb_regs.sv
// ----------------------------------------------------------------------------
// Switch debounce configuration registers
// APB-style register file holding window length, tolerance, press level,
// idle level and window mode.
// ----------------------------------------------------------------------------
`default_nettype none

module sdt_apb_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sdt_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [sdt_pkg::DATA_W-1:0]   pwdata,
    output logic      [sdt_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    output sdt_pkg::cfg_t                     cfg
);

    sdt_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[sdt_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // Register writes on the access cycle of a transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_length <= 8'd8;
            cfg_reg.tolerance     <= 8'd1;
            cfg_reg.active_level  <= 1'b0;
            cfg_reg.idle_level    <= 1'b1;
            cfg_reg.window_mode   <= sdt_pkg::MODE_BLOCK;
        end else if (wr_en) begin
            unique case (reg_idx)
                sdt_pkg::REG_WINDOW_LENGTH: cfg_reg.window_length <= pwdata[7:0];
                sdt_pkg::REG_TOLERANCE:     cfg_reg.tolerance     <= pwdata[7:0];
                sdt_pkg::REG_ACTIVE_LEVEL:  cfg_reg.active_level  <= pwdata[0];
                sdt_pkg::REG_IDLE_LEVEL:    cfg_reg.idle_level    <= pwdata[0];
                sdt_pkg::REG_WINDOW_MODE:
                    cfg_reg.window_mode <= sdt_pkg::mode_t'(pwdata[0]);
                default: ;
            endcase
        end
    end

    // Read data, zero beyond the register list.
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            sdt_pkg::REG_WINDOW_LENGTH: prdata[7:0] = cfg_reg.window_length;
            sdt_pkg::REG_TOLERANCE:     prdata[7:0] = cfg_reg.tolerance;
            sdt_pkg::REG_ACTIVE_LEVEL:  prdata[0]   = cfg_reg.active_level;
            sdt_pkg::REG_IDLE_LEVEL:    prdata[0]   = cfg_reg.idle_level;
            sdt_pkg::REG_WINDOW_MODE:   prdata[0]   = cfg_reg.window_mode;
            default:                    prdata      = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/sdt_core.sv
// ----------------------------------------------------------------------------
// Switch debounce core
// Input register, debounce state with block counters and sliding sample
// line, and a result register that decouples the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module sdt_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire sdt_pkg::cfg_t    cfg,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire sdt_pkg::action_t in_action,
    input  wire logic             in_pin,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output sdt_pkg::event_t       out_event,
    output logic                  out_stable
);

    localparam int DEPTH  = sdt_pkg::SAMPLES_DEPTH;
    localparam int ONES_W = sdt_pkg::ONES_W;

    // Pipeline registers.
    logic              in_vld_reg;
    sdt_pkg::action_t  in_action_reg;
    logic              in_pin_reg;
    logic              out_vld_reg;
    sdt_pkg::event_t   out_event_reg;
    logic              out_stable_reg;

    // Debounce state.
    logic              deb_reg,        deb_next;
    logic [7:0]        blk_count_reg,  blk_count_next;
    logic [7:0]        blk_ones_reg,   blk_ones_next;
    logic [DEPTH-1:0]  ring_reg,       ring_next;
    logic [ONES_W-1:0] ring_ones_reg,  ring_ones_next;

    logic              advance;
    logic              in_take;
    logic [7:0]        cnt_inc;
    logic [7:0]        ones_inc;
    sdt_pkg::level_t   level;
    sdt_pkg::event_t   event_next;

    // The result register frees when empty or when its transfer completes.
    assign advance  = !out_vld_reg || out_ready;
    assign in_ready = !in_vld_reg || advance;
    assign in_take  = in_valid && in_ready;

    assign out_valid  = out_vld_reg;
    assign out_event  = out_event_reg;
    assign out_stable = out_stable_reg;

    // Input register stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (in_take) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_action_reg <= in_action;
            in_pin_reg    <= in_pin;
        end
    end

    assign cnt_inc  = blk_count_reg + 8'd1;
    assign ones_inc = blk_ones_reg + {7'd0, in_pin_reg};

    // Next state, decision and event for the item in the input register.
    always_comb begin
        deb_next       = deb_reg;
        blk_count_next = blk_count_reg;
        blk_ones_next  = blk_ones_reg;
        ring_next      = ring_reg;
        ring_ones_next = ring_ones_reg;
        level          = sdt_pkg::LVL_UNDECIDED;
        event_next     = sdt_pkg::EV_NONE;

        if (in_action_reg == sdt_pkg::ACT_RESTART) begin
            deb_next       = cfg.idle_level;
            blk_count_next = 8'd0;
            blk_ones_next  = 8'd0;
            ring_next      = {DEPTH{cfg.idle_level}};
            ring_ones_next = cfg.idle_level ? ONES_W'(DEPTH) : '0;
        end else if (cfg.window_mode == sdt_pkg::MODE_BLOCK) begin
            blk_count_next = cnt_inc;
            blk_ones_next  = ones_inc;
            if (cnt_inc >= cfg.window_length) begin
                level          = sdt_pkg::judge(ones_inc, cnt_inc, cfg.tolerance);
                blk_count_next = 8'd0;
                blk_ones_next  = 8'd0;
            end
        end else begin
            // The oldest sample leaves at the far end of the line.
            ring_next      = {ring_reg[DEPTH-2:0], in_pin_reg};
            ring_ones_next = ring_ones_reg - ONES_W'(ring_reg[DEPTH-1])
                             + ONES_W'(in_pin_reg);
            level = sdt_pkg::judge(8'(ring_ones_next), sdt_pkg::DEPTH_COUNT,
                                   cfg.tolerance);
        end

        if (level != sdt_pkg::LVL_UNDECIDED &&
            (level == sdt_pkg::LVL_HIGH) != deb_reg) begin
            deb_next   = (level == sdt_pkg::LVL_HIGH);
            event_next = ((level == sdt_pkg::LVL_HIGH) == cfg.active_level) ?
                         sdt_pkg::EV_PRESS : sdt_pkg::EV_RELEASE;
        end
    end

    // State update and result register, both move when the item advances.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg   <= 1'b0;
            deb_reg       <= 1'b1;
            blk_count_reg <= 8'd0;
            blk_ones_reg  <= 8'd0;
            ring_reg      <= {DEPTH{1'b1}};
            ring_ones_reg <= ONES_W'(DEPTH);
        end else if (advance) begin
            out_vld_reg <= in_vld_reg;
            if (in_vld_reg) begin
                deb_reg       <= deb_next;
                blk_count_reg <= blk_count_next;
                blk_ones_reg  <= blk_ones_next;
                ring_reg      <= ring_next;
                ring_ones_reg <= ring_ones_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_vld_reg) begin
            out_event_reg  <= event_next;
            out_stable_reg <= deb_next;
        end
    end

endmodule

`default_nettype wire
